/* hdl/bis_pkg.sv */
`default_nettype none

package bis_pkg;

  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int MAX_DST_SIZE   = 4096;

  localparam int COORD_W    = 12;
  localparam int CHAN_W     = 8;
  localparam int RGB_W      = 3 * CHAN_W;
  localparam int SW_W       = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SH_W       = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int SX_W       = $clog2(MAX_SRC_WIDTH);
  localparam int SY_W       = $clog2(MAX_SRC_HEIGHT);
  localparam int DIM_W      = $clog2(MAX_DST_SIZE + 1);
  localparam int DEN_W      = 2 * DIM_W - 1;
  localparam int SUM_W      = DEN_W + CHAN_W;
  localparam int MULT_W     = COORD_W + ((SW_W > SH_W) ? SW_W : SH_W);
  localparam int NUMD_W     = DIM_W + ((SW_W > SH_W) ? SW_W : SH_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [CHAN_W-1:0]  red_in;
    logic [CHAN_W-1:0]  green_in;
    logic [CHAN_W-1:0]  blue_in;
  } req_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              outside;
  } rsp_t;

  // effective sizes after clamping and aspect derivation
  typedef struct packed {
    logic [SW_W-1:0]  sw;
    logic [SH_W-1:0]  sh;
    logic [DIM_W-1:0] dw;
    logic [DIM_W-1:0] dh;
    logic [DEN_W-1:0] den;
  } cfg_t;

endpackage

`default_nettype wire

/* hdl/bis_if.sv */
`default_nettype none

interface bis_req_if;
  import bis_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bis_rsp_if;
  import bis_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/bilinear_image_scaler.sv */
// pipeline: 13 stages, then the output register, lie between acceptance and a compute result
// throughput: one request per cycle unless the output stalls; loads take a slot, give no result
// after each config write the input holds ready low while the
//   aspect ratio derivation (one quotient bit a cycle) and the weight denominator settle
// reset: async active low, clears valid bits, config to 256/256/0/0; source store is not cleared
`default_nettype none

module bilinear_image_scaler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bis_req_if.sink                        req_i,
  bis_rsp_if.source                      rsp_o,
  input  logic                           cfg_we_i,
  input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import bis_pkg::*;

  // stage map:
  //   0      : x*sw, y*sh products, outside check
  //   1..4   : coordinate dividers, two quotient bits per stage
  //   5 (A)  : clamp, neighbour columns/rows, bank addresses, weights
  //   6 (B)  : banked store read data
  //   7 (C)  : channel times weight products
  //   8 (D)  : four-term sums
  //   9..12  : normalizing divider by dw*dh, two quotient bits per stage
  localparam int NSTG    = 13;
  localparam int ST_A    = 5;
  localparam int ST_B    = 6;
  localparam int ST_LAST = NSTG - 1;
  localparam int NDIV    = 4;
  localparam int QB      = 2 * NDIV;
  localparam int NBANK   = 4;
  localparam int BANK_D  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT / NBANK;
  localparam int BA_W    = $clog2(BANK_D);

  typedef struct packed {
    logic              valid;
    logic              comp;
    logic              outside;
    logic              wr;
    logic [SX_W-1:0]   lx;
    logic [SY_W-1:0]   ly;
    logic [RGB_W-1:0]  rgb;
  } ctl_t;

  // neighbour parities, they pick the bank that holds each of the four pixels
  typedef struct packed {
    logic x1;
    logic x2;
    logic y1;
    logic y2;
  } par_t;

  function automatic logic [SUM_W:0] dstep(input logic [SUM_W-1:0] r,
                                           input logic [SUM_W-1:0] ds);
    logic ge;
    ge = (r >= ds);
    return {ge, ge ? r - ds : r};
  endfunction

  cfg_t eff;
  logic cfg_busy;

  bis_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .eff_o       (eff),
    .busy_o      (cfg_busy)
  );

  // ------------------------------------------------------------------
  // flow control: the whole pipe moves together; it may move while a result
  // waits in the output register as long as the last stage has no result
  // ------------------------------------------------------------------
  ctl_t ctl_q [NSTG];
  logic out_valid_q;
  rsp_t out_q;
  logic last_res;
  logic out_load;
  logic adv;
  logic accept;

  assign last_res    = ctl_q[ST_LAST].valid & ctl_q[ST_LAST].comp;
  assign out_load    = !out_valid_q | rsp_o.ready;
  assign adv         = out_load | !last_res;
  assign req_i.ready = adv & !cfg_busy;
  assign accept      = req_i.valid & req_i.ready;

  // ------------------------------------------------------------------
  // coordinate dividers: inside the destination, quotient < source size, so 8 bits suffice
  // ------------------------------------------------------------------
  logic [MULT_W-1:0] xr_q [NDIV+1];
  logic [SX_W-1:0]   xq_q [NDIV+1];
  logic [MULT_W-1:0] yr_q [NDIV+1];
  logic [SY_W-1:0]   yq_q [NDIV+1];
  logic [MULT_W-1:0] xr_d [NDIV+1];
  logic [SX_W-1:0]   xq_d [NDIV+1];
  logic [MULT_W-1:0] yr_d [NDIV+1];
  logic [SY_W-1:0]   yq_d [NDIV+1];

  always_comb begin
    logic [MULT_W-1:0] rx;
    logic [MULT_W-1:0] ry;
    logic [SX_W-1:0]   qx;
    logic [SY_W-1:0]   qy;
    logic [SUM_W:0]    t;
    int                k;
    xr_d[0] = xr_q[0];
    xq_d[0] = xq_q[0];
    yr_d[0] = yr_q[0];
    yq_d[0] = yq_q[0];
    for (int s = 1; s <= NDIV; s++) begin
      rx = xr_q[s-1];
      qx = xq_q[s-1];
      ry = yr_q[s-1];
      qy = yq_q[s-1];
      for (int j = 0; j < 2; j++) begin
        k     = QB + 1 - 2 * s - j;
        t     = dstep(SUM_W'(rx), SUM_W'(eff.dw) << k);
        qx[k] = t[SUM_W];
        rx    = MULT_W'(t[SUM_W-1:0]);
        t     = dstep(SUM_W'(ry), SUM_W'(eff.dh) << k);
        qy[k] = t[SUM_W];
        ry    = MULT_W'(t[SUM_W-1:0]);
      end
      xr_d[s] = rx;
      xq_d[s] = qx;
      yr_d[s] = ry;
      yq_d[s] = qy;
    end
  end

  // ------------------------------------------------------------------
  // stage A: neighbours, bank addressing and bilinear weights
  // ------------------------------------------------------------------
  logic [DIM_W-1:0] rem_x, rem_y;
  logic [SX_W-1:0]  x1c, x2c;
  logic [SY_W-1:0]  y1c, y2c;
  logic [SX_W:0]    x2w;
  logic [SY_W:0]    y2w;
  logic [DIM_W-1:0] wx0, wy0;
  logic [BA_W-1:0]  raddr_d [NBANK];
  logic [DEN_W-1:0] w_d [NBANK];
  par_t             par_d;

  always_comb begin
    logic [SX_W-1:0] col;
    logic [SY_W-1:0] row;
    rem_x = DIM_W'(xr_q[NDIV]);
    rem_y = DIM_W'(yr_q[NDIV]);
    x1c   = ({1'b0, xq_q[NDIV]} >= eff.sw) ? SX_W'(eff.sw - 1'b1) : xq_q[NDIV];
    y1c   = ({1'b0, yq_q[NDIV]} >= eff.sh) ? SY_W'(eff.sh - 1'b1) : yq_q[NDIV];
    // right and lower neighbours only when the remainder is nonzero, clamped to the edge
    x2w   = (rem_x != '0) ? {1'b0, x1c} + 1'b1 : {1'b0, x1c};
    y2w   = (rem_y != '0) ? {1'b0, y1c} + 1'b1 : {1'b0, y1c};
    x2c   = (x2w >= eff.sw) ? SX_W'(eff.sw - 1'b1) : x2w[SX_W-1:0];
    y2c   = (y2w >= eff.sh) ? SY_W'(eff.sh - 1'b1) : y2w[SY_W-1:0];
    wx0   = eff.dw - rem_x;
    wy0   = eff.dh - rem_y;
    // weight order: (x1,y1) (x1,y2) (x2,y1) (x2,y2)
    w_d[0] = DEN_W'(DEN_W'(wx0) * DEN_W'(wy0));
    w_d[1] = DEN_W'(DEN_W'(wx0) * DEN_W'(rem_y));
    w_d[2] = DEN_W'(DEN_W'(rem_x) * DEN_W'(wy0));
    w_d[3] = DEN_W'(DEN_W'(rem_x) * DEN_W'(rem_y));
    par_d  = '{x1: x1c[0], x2: x2c[0], y1: y1c[0], y2: y2c[0]};
    // banks split by column and row parity; x1/x2 differ in parity unless equal
    for (int b = 0; b < NBANK; b++) begin
      col        = (x1c[0] == b[0]) ? x1c : x2c;
      row        = (y1c[0] == b[1]) ? y1c : y2c;
      raddr_d[b] = {row[SY_W-1:1], col[SX_W-1:1]};
    end
  end

  logic [BA_W-1:0]  raddr_q [NBANK];
  logic [DEN_W-1:0] wa_q [NBANK];
  logic [DEN_W-1:0] wb_q [NBANK];
  par_t             para_q;
  par_t             parb_q;
  logic [RGB_W-1:0] rdata [NBANK];

  // loads write in stage A, so any later compute already sees the pixel
  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    localparam logic [1:0] BANK_ID = 2'(b);
    logic bank_we;
    assign bank_we = adv & ctl_q[ST_A].valid & !ctl_q[ST_A].comp & ctl_q[ST_A].wr &
                     (ctl_q[ST_A].lx[0] == BANK_ID[0]) & (ctl_q[ST_A].ly[0] == BANK_ID[1]);
    bis_ram #(
      .Width (RGB_W),
      .Depth (BANK_D)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we),
      .waddr_i ({ctl_q[ST_A].ly[SY_W-1:1], ctl_q[ST_A].lx[SX_W-1:1]}),
      .wdata_i (ctl_q[ST_A].rgb),
      .re_i    (adv),
      .raddr_i (raddr_q[b]),
      .rdata_o (rdata[b])
    );
  end

  // ------------------------------------------------------------------
  // stage C/D: channel products and sums
  // ------------------------------------------------------------------
  logic [RGB_W-1:0] pix [NBANK];
  logic [SUM_W-1:0] prod_q [3][NBANK];
  logic [SUM_W-1:0] er_q [3][NDIV+1];
  logic [CHAN_W-1:0] eq_q [3][NDIV+1];
  logic [SUM_W-1:0] er_d [3][NDIV+1];
  logic [CHAN_W-1:0] eq_d [3][NDIV+1];

  always_comb begin
    pix[0] = rdata[{parb_q.y1, parb_q.x1}];
    pix[1] = rdata[{parb_q.y2, parb_q.x1}];
    pix[2] = rdata[{parb_q.y1, parb_q.x2}];
    pix[3] = rdata[{parb_q.y2, parb_q.x2}];
  end

  // normalizing divide: weights add up to dw*dh, so the quotient never exceeds 255
  always_comb begin
    logic [SUM_W-1:0]  r;
    logic [CHAN_W-1:0] q;
    logic [SUM_W:0]    t;
    int                k;
    for (int c = 0; c < 3; c++) begin
      er_d[c][0] = er_q[c][0];
      eq_d[c][0] = eq_q[c][0];
      for (int s = 1; s <= NDIV; s++) begin
        r = er_q[c][s-1];
        q = eq_q[c][s-1];
        for (int j = 0; j < 2; j++) begin
          k    = QB + 1 - 2 * s - j;
          t    = dstep(r, SUM_W'(eff.den) << k);
          q[k] = t[SUM_W];
          r    = t[SUM_W-1:0];
        end
        er_d[c][s] = r;
        eq_d[c][s] = q;
      end
    end
  end

  // ------------------------------------------------------------------
  // control ribbon, valid bits under reset
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTG; i++) begin
        ctl_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        ctl_q[0].valid   <= accept;
        ctl_q[0].comp    <= req_i.data.action;
        ctl_q[0].outside <= ({1'b0, req_i.data.coord_x} >= eff.dw) |
                            ({1'b0, req_i.data.coord_y} >= eff.dh);
        ctl_q[0].wr      <= (req_i.data.coord_x < COORD_W'(MAX_SRC_WIDTH)) &
                            (req_i.data.coord_y < COORD_W'(MAX_SRC_HEIGHT));
        ctl_q[0].lx      <= req_i.data.coord_x[SX_W-1:0];
        ctl_q[0].ly      <= req_i.data.coord_y[SY_W-1:0];
        ctl_q[0].rgb     <= {req_i.data.red_in, req_i.data.green_in, req_i.data.blue_in};
        for (int i = 1; i < NSTG; i++) begin
          ctl_q[i] <= ctl_q[i-1];
        end
      end
      if (out_load) begin
        out_valid_q <= last_res;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (adv) begin
      xr_q[0] <= MULT_W'(MULT_W'(req_i.data.coord_x) * MULT_W'(eff.sw));
      yr_q[0] <= MULT_W'(MULT_W'(req_i.data.coord_y) * MULT_W'(eff.sh));
      xq_q[0] <= '0;
      yq_q[0] <= '0;
      for (int s = 1; s <= NDIV; s++) begin
        xr_q[s] <= xr_d[s];
        xq_q[s] <= xq_d[s];
        yr_q[s] <= yr_d[s];
        yq_q[s] <= yq_d[s];
      end
      for (int b = 0; b < NBANK; b++) begin
        raddr_q[b] <= raddr_d[b];
        wa_q[b]    <= w_d[b];
        wb_q[b]    <= wa_q[b];
      end
      para_q <= par_d;
      parb_q <= para_q;
      for (int c = 0; c < 3; c++) begin
        for (int n = 0; n < NBANK; n++) begin
          prod_q[c][n] <= SUM_W'(SUM_W'(pix[n][RGB_W-1-CHAN_W*c -: CHAN_W]) *
                                 SUM_W'(wb_q[n]));
        end
        er_q[c][0] <= prod_q[c][0] + prod_q[c][1] + prod_q[c][2] + prod_q[c][3];
        eq_q[c][0] <= '0;
        for (int s = 1; s <= NDIV; s++) begin
          er_q[c][s] <= er_d[c][s];
          eq_q[c][s] <= eq_d[c][s];
        end
      end
    end
    if (out_load) begin
      out_q.outside   <= ctl_q[ST_LAST].outside;
      out_q.red_out   <= ctl_q[ST_LAST].outside ? '0 : eq_q[0][NDIV];
      out_q.green_out <= ctl_q[ST_LAST].outside ? '0 : eq_q[1][NDIV];
      out_q.blue_out  <= ctl_q[ST_LAST].outside ? '0 : eq_q[2][NDIV];
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // no request gets in while the size derivation is running
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_busy |-> !(req_i.valid && req_i.ready))
    else $error("request accepted while config derivation busy");

  // a free output register always lets the pipe move
  a_free_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> adv)
    else $error("pipe stalled with empty output register");

  // a stalled pipe keeps its last stage
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(ctl_q[ST_LAST]))
    else $error("last stage changed during stall");

  // an item at the address stage moves on to the read stage
  a_stage_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && ctl_q[ST_A].valid) |=> ctl_q[ST_B].valid)
    else $error("item lost between address and read stages");

endmodule

`default_nettype wire

/* hdl/bis_ram.sv */
`default_nettype none

module bis_ram #(
  parameter int Width = 24,
  parameter int Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/bis_cfg.sv */
`default_nettype none

module bis_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output bis_pkg::cfg_t                  eff_o,
  output logic                           busy_o
);
  import bis_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DEN  = 2'd3;
  localparam int CNT_W = $clog2(NUMD_W);
  localparam int RD_W  = (SW_W > SH_W) ? SW_W : SH_W;

  logic [SW_W-1:0]   sw_raw_q;
  logic [SH_W-1:0]   sh_raw_q;
  logic [DIM_W-1:0]  dw_raw_q;
  logic [DIM_W-1:0]  dh_raw_q;
  logic [1:0]        state_q;
  cfg_t              eff_q;
  logic [NUMD_W-1:0] num_q;
  logic [RD_W-1:0]   dvs_q;
  logic [RD_W-1:0]   rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              deriv_h_q;

  logic [SW_W-1:0]   sw_c;
  logic [SH_W-1:0]   sh_c;
  logic [DIM_W-1:0]  dw_c;
  logic [DIM_W-1:0]  dh_c;
  logic [RD_W:0]     trial;
  logic              ge;
  logic [RD_W-1:0]   rem_n;
  logic [NUMD_W-1:0] quo_n;
  logic [DIM_W-1:0]  quo_sat;

  always_comb begin
    sw_c = (sw_raw_q == '0) ? SW_W'(1) :
           (sw_raw_q > SW_W'(MAX_SRC_WIDTH)) ? SW_W'(MAX_SRC_WIDTH) : sw_raw_q;
    sh_c = (sh_raw_q == '0) ? SH_W'(1) :
           (sh_raw_q > SH_W'(MAX_SRC_HEIGHT)) ? SH_W'(MAX_SRC_HEIGHT) : sh_raw_q;
    dw_c = (dw_raw_q > DIM_W'(MAX_DST_SIZE)) ? DIM_W'(MAX_DST_SIZE) : dw_raw_q;
    dh_c = (dh_raw_q > DIM_W'(MAX_DST_SIZE)) ? DIM_W'(MAX_DST_SIZE) : dh_raw_q;
    // one restoring step a cycle, quotient shifts in behind the numerator
    trial   = {rem_q, num_q[NUMD_W-1]};
    ge      = trial >= {1'b0, dvs_q};
    rem_n   = ge ? RD_W'(trial - {1'b0, dvs_q}) : RD_W'(trial);
    quo_n   = {num_q[NUMD_W-2:0], ge};
    quo_sat = (quo_n > NUMD_W'(MAX_DST_SIZE)) ? DIM_W'(MAX_DST_SIZE) : quo_n[DIM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_raw_q  <= SW_W'(MAX_SRC_WIDTH);
      sh_raw_q  <= SH_W'(MAX_SRC_HEIGHT);
      dw_raw_q  <= '0;
      dh_raw_q  <= '0;
      state_q   <= ST_IDLE;
      eff_q.sw  <= SW_W'(MAX_SRC_WIDTH);
      eff_q.sh  <= SH_W'(MAX_SRC_HEIGHT);
      eff_q.dw  <= DIM_W'(MAX_SRC_WIDTH);
      eff_q.dh  <= DIM_W'(MAX_SRC_HEIGHT);
      eff_q.den <= DEN_W'(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
      num_q     <= '0;
      dvs_q     <= '0;
      rem_q     <= '0;
      cnt_q     <= '0;
      deriv_h_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SRC_WIDTH:  sw_raw_q <= cfg_wdata_i[SW_W-1:0];
        REG_SRC_HEIGHT: sh_raw_q <= cfg_wdata_i[SH_W-1:0];
        REG_DST_WIDTH:  dw_raw_q <= cfg_wdata_i[DIM_W-1:0];
        REG_DST_HEIGHT: dh_raw_q <= cfg_wdata_i[DIM_W-1:0];
      endcase
      state_q <= ST_LOAD;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
        end
        ST_LOAD: begin
          eff_q.sw <= sw_c;
          eff_q.sh <= sh_c;
          rem_q    <= '0;
          cnt_q    <= '0;
          if (dw_c == '0 && dh_c == '0) begin
            eff_q.dw <= DIM_W'(sw_c);
            eff_q.dh <= DIM_W'(sh_c);
            state_q  <= ST_DEN;
          end else if (dw_c != '0 && dh_c != '0) begin
            eff_q.dw <= dw_c;
            eff_q.dh <= dh_c;
            state_q  <= ST_DEN;
          end else if (dh_c == '0) begin
            eff_q.dw  <= dw_c;
            num_q     <= NUMD_W'(dw_c) * NUMD_W'(sh_c);
            dvs_q     <= RD_W'(sw_c);
            deriv_h_q <= 1'b1;
            state_q   <= ST_DIV;
          end else begin
            eff_q.dh  <= dh_c;
            num_q     <= NUMD_W'(dh_c) * NUMD_W'(sw_c);
            dvs_q     <= RD_W'(sh_c);
            deriv_h_q <= 1'b0;
            state_q   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q <= rem_n;
          num_q <= quo_n;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(NUMD_W - 1)) begin
            if (deriv_h_q) begin
              eff_q.dh <= quo_sat;
            end else begin
              eff_q.dw <= quo_sat;
            end
            state_q <= ST_DEN;
          end
        end
        ST_DEN: begin
          eff_q.den <= DEN_W'(DEN_W'(eff_q.dw) * DEN_W'(eff_q.dh));
          state_q   <= ST_IDLE;
        end
      endcase
    end
  end

  assign eff_o  = eff_q;
  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

/* tb/bis_scoreboard.sv */
`timescale 1ns / 1ps

module bis_scoreboard
  import bis_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bis_req_if                    req,
  bis_rsp_if                    rsp,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    pending_o,
  output int                    errors_o,
  output int                    pixels_checked_o
);

  logic [RGB_W-1:0] pixel_mem [0:MAX_SRC_WIDTH*MAX_SRC_HEIGHT-1];
  logic [8:0]       src_w_q, src_h_q;
  logic [12:0]      dst_w_q, dst_h_q;
  rsp_t             expected_px [$];

  initial begin
    for (int i = 0; i < MAX_SRC_WIDTH * MAX_SRC_HEIGHT; i++) pixel_mem[i] = '0;
    pending_o = 0;
    errors_o = 0;
    pixels_checked_o = 0;
  end

  function automatic longint unsigned clip(longint unsigned v, longint unsigned lo,
                                           longint unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [RGB_W-1:0] pixel_at(longint unsigned x, longint unsigned y);
    return pixel_mem[y * MAX_SRC_WIDTH + x];
  endfunction

  // bilinear interpolation of one destination pixel
  function automatic rsp_t scale_pixel(req_t r);
    longint unsigned sw, sh, dw, dh, x, y, rx, ry, x1, x2, y1, y2, den, acc, v;
    longint unsigned wt [4];
    logic [RGB_W-1:0] px [4];
    rsp_t o;
    o = '0;
    x = r.coord_x;
    y = r.coord_y;
    sw = clip(src_w_q, 1, MAX_SRC_WIDTH);
    sh = clip(src_h_q, 1, MAX_SRC_HEIGHT);
    dw = clip(dst_w_q, 0, MAX_DST_SIZE);
    dh = clip(dst_h_q, 0, MAX_DST_SIZE);
    if (dw == 0 && dh == 0) begin
      if (x >= sw || y >= sh) begin
        o.outside = 1'b1;
      end else begin
        px[0] = pixel_at(x, y);
        {o.red_out, o.green_out, o.blue_out} = px[0];
      end
      return o;
    end
    if (dh == 0) dh = clip(dw * sh / sw, 0, MAX_DST_SIZE);
    else if (dw == 0) dw = clip(dh * sw / sh, 0, MAX_DST_SIZE);
    if (x >= dw || y >= dh) begin
      o.outside = 1'b1;
      return o;
    end
    rx = (x * sw) % dw;
    x1 = (x * sw) / dw;
    x2 = (rx > 0) ? x1 + 1 : x1;
    ry = (y * sh) % dh;
    y1 = (y * sh) / dh;
    y2 = (ry > 0) ? y1 + 1 : y1;
    if (x1 >= sw) x1 = sw - 1;
    if (x2 >= sw) x2 = sw - 1;
    if (y1 >= sh) y1 = sh - 1;
    if (y2 >= sh) y2 = sh - 1;
    wt[0] = (dw - rx) * (dh - ry);
    wt[1] = (dw - rx) * ry;
    wt[2] = rx * (dh - ry);
    wt[3] = rx * ry;
    den = dw * dh;
    px[0] = pixel_at(x1, y1);
    px[1] = pixel_at(x1, y2);
    px[2] = pixel_at(x2, y1);
    px[3] = pixel_at(x2, y2);
    for (int c = 0; c < 3; c++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) acc += longint'(px[k][16-8*c +: 8]) * wt[k];
      v = acc / den;
      if (v > 255) v = 255;
      case (c)
        0: o.red_out = v[7:0];
        1: o.green_out = v[7:0];
        default: o.blue_out = v[7:0];
      endcase
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t got, want;
    if (!rst_ni) begin
      src_w_q <= 9'd256;
      src_h_q <= 9'd256;
      dst_w_q <= 13'd0;
      dst_h_q <= 13'd0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SRC_WIDTH:  src_w_q <= cfg_wdata_i[8:0];
          REG_SRC_HEIGHT: src_h_q <= cfg_wdata_i[8:0];
          REG_DST_WIDTH:  dst_w_q <= cfg_wdata_i[12:0];
          REG_DST_HEIGHT: dst_h_q <= cfg_wdata_i[12:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (!req.data.action) begin
          // loads beyond the store are dropped
          if (req.data.coord_x < MAX_SRC_WIDTH && req.data.coord_y < MAX_SRC_HEIGHT)
            pixel_mem[req.data.coord_y * MAX_SRC_WIDTH + req.data.coord_x] =
              {req.data.red_in, req.data.green_in, req.data.blue_in};
        end else begin
          expected_px.insert(expected_px.size(), scale_pixel(req.data));
        end
      end
      if (rsp.valid && rsp.ready) begin
        got = rsp.data;
        if (expected_px.size() == 0) begin
          $display("%0t: unexpected pixel %h", $time, got);
          errors_o++;
        end else begin
          want = expected_px.pop_front();
          pixels_checked_o++;
          if (got.red_out !== want.red_out) begin
            $display("%0t: red exp %0d got %0d", $time, want.red_out, got.red_out);
            errors_o++;
          end
          if (got.green_out !== want.green_out) begin
            $display("%0t: green exp %0d got %0d", $time, want.green_out, got.green_out);
            errors_o++;
          end
          if (got.blue_out !== want.blue_out) begin
            $display("%0t: blue exp %0d got %0d", $time, want.blue_out, got.blue_out);
            errors_o++;
          end
          if (got.outside !== want.outside) begin
            $display("%0t: outside exp %0b got %0b", $time, want.outside, got.outside);
            errors_o++;
          end
        end
      end
      pending_o = expected_px.size();
    end
  end

endmodule

/* tb/tb_bilinear_image_scaler.sv */
`timescale 1ns / 1ps

module tb_bilinear_image_scaler;
  import bis_pkg::*;

  localparam int TIMEOUT_CYCLES = 600000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bis_req_if req_if ();
  bis_rsp_if rsp_if ();

  int pending, errors, pixels_checked;
  int cycles;
  int burst_left;
  int loads_sent, computes_sent, settings_used;
  bit hold_go;
  // current source region, bounds for in-region loads
  int region_w, region_h, coord_span;

  bilinear_image_scaler u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  bis_scoreboard u_scoreboard (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .req              (req_if),
    .rsp              (rsp_if),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .pending_o        (pending),
    .errors_o         (errors),
    .pixels_checked_o (pixels_checked)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: stall pattern picked afresh for each window, plus one long hold
  initial begin
    int mode;
    int hold_left;
    bit hold_done;
    hold_done = 1'b0;
    hold_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat (64) begin
        @(negedge clk);
        if (hold_go && !hold_done) begin
          // long hold so the pipe fills and input ready drops
          if (hold_left == 0) hold_left = 400;
          hold_left--;
          if (hold_left == 0) hold_done = 1'b1;
          rsp_if.ready <= 1'b0;
        end else begin
          case (mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
            default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  // one request, sent in bursts with random gaps between them
  task automatic send(req_t r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        req_if.valid <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end
    end
    @(negedge clk);
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    burst_left--;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    if (r.action) computes_sent++;
    else loads_sent++;
  endtask

  task automatic load_px(int x, int y, logic [23:0] rgb);
    req_t r;
    r = '0;
    r.action = 1'b0;
    r.coord_x = x[COORD_W-1:0];
    r.coord_y = y[COORD_W-1:0];
    {r.red_in, r.green_in, r.blue_in} = rgb;
    send(r);
  endtask

  task automatic compute_px(int x, int y);
    req_t r;
    r = '0;
    {r.red_in, r.green_in, r.blue_in} = 24'($urandom);
    r.action = 1'b1;
    r.coord_x = x[COORD_W-1:0];
    r.coord_y = y[COORD_W-1:0];
    send(r);
  endtask

  // drain: drop valid, wait out all results and the pipe depth
  task automatic drain();
    @(negedge clk);
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // only called when idle
  task automatic set_geometry(int sw, int sh, int dw, int dh);
    int m;
    drain();
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    settings_used++;
    m = (dw > dh) ? dw : dh;
    if (sw > m) m = sw;
    if (sh > m) m = sh;
    coord_span = (m + 3 > 4095) ? 4095 : m + 3;
  endtask

  function automatic int pick_dst();
    int m;
    m = $urandom_range(0, 9);
    if (m < 2) return 0;
    if (m < 7) return $urandom_range(1, 64);
    if (m < 9) return $urandom_range(65, MAX_DST_SIZE);
    return $urandom_range(MAX_DST_SIZE + 1, 8191);
  endfunction

  initial begin
    int sw, sh, cls, sel, x, y;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    hold_go      = 1'b0;
    burst_left   = 0;
    loads_sent = 0;
    computes_sent = 0;
    settings_used = 0;
    coord_span = 259;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every pixel a compute may touch gets loaded first:
    // a 16x16 corner, the rest of row 0 and the rest of column 0
    for (y = 0; y < 16; y++)
      for (x = 0; x < 16; x++)
        load_px(x, y, (x + y) % 5 == 0 ? 24'hffffff : 24'($urandom));
    load_px(0, 0, 24'h000000);
    load_px(15, 15, 24'hff00ff);
    for (x = 16; x < MAX_SRC_WIDTH; x++) load_px(x, 0, 24'($urandom));
    for (y = 16; y < MAX_SRC_HEIGHT; y++) load_px(0, y, 24'($urandom));

    // loads beyond the store are ignored
    load_px(4095, 4095, 24'hffffff);
    load_px(MAX_SRC_WIDTH, 0, 24'h123456);
    load_px(0, MAX_SRC_HEIGHT, 24'h654321);

    // reset geometry: straight copy of a 256x256 source
    compute_px(0, 0);
    compute_px(255, 0);
    compute_px(0, 255);
    compute_px(256, 0);
    compute_px(4095, 4095);
    // copy within a 16x16 source, edge and just past it
    set_geometry(16, 16, 0, 0);
    compute_px(15, 15);
    compute_px(16, 3);
    // upscale, last row and column clamp
    set_geometry(16, 16, 32, 32);
    compute_px(1, 1);
    compute_px(31, 31);
    compute_px(32, 0);
    // one destination size derived from the aspect ratio
    set_geometry(16, 16, 8, 0);
    compute_px(7, 7);
    set_geometry(16, 10, 0, 5);
    compute_px(7, 4);
    // zero source sizes count as one
    set_geometry(0, 0, 3, 3);
    compute_px(2, 2);
    // oversized registers saturate
    set_geometry(511, 1, 8191, 0);
    compute_px(4095, 15);
    set_geometry(1, 511, 0, MAX_DST_SIZE);
    compute_px(15, 4095);
    set_geometry(16, 16, MAX_DST_SIZE, MAX_DST_SIZE);
    compute_px(4095, 4095);
    // derived size truncates to zero, so everything is outside
    set_geometry(16, 9, 1, 0);
    compute_px(0, 0);

    // random phases
    for (int phase = 0; phase < 10; phase++) begin
      cls = $urandom_range(0, 5);
      if (cls < 4) begin
        sw = $urandom_range(0, 16);
        sh = $urandom_range(0, 16);
        region_w = (sw == 0) ? 1 : sw;
        region_h = (sh == 0) ? 1 : sh;
      end else if (cls == 4) begin
        sw = $urandom_range(1, 511);
        sh = $urandom_range(0, 1);
        region_w = (sw > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : sw;
        region_h = 1;
      end else begin
        sw = $urandom_range(0, 1);
        sh = $urandom_range(1, 511);
        region_w = 1;
        region_h = (sh > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : sh;
      end
      set_geometry(sw, sh, pick_dst(), pick_dst());
      if (phase == 3) hold_go = 1'b1;
      repeat (16) begin
        sel = $urandom_range(0, 19);
        if (sel < 5) begin
          load_px($urandom_range(0, region_w - 1), $urandom_range(0, region_h - 1),
                  24'($urandom));
        end else if (sel == 5) begin
          load_px($urandom_range(0, 4095), $urandom_range(0, 4095), 24'($urandom));
        end else if (sel == 6) begin
          compute_px($urandom_range(0, 4095), $urandom_range(0, 4095));
        end else begin
          compute_px($urandom_range(0, coord_span), $urandom_range(0, coord_span));
        end
      end
    end

    drain();
    $display("covered %0d loads and %0d computes over %0d geometries, %0d pixels compared",
             loads_sent, computes_sent, settings_used, pixels_checked);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
